@@ rtl/cmtt_pkg.sv @@
// Package for the cut merge truth table block: widths, constants, transaction
// structs, swap and support-test functions. Used by every file but cmtt_if; depends on nothing.
`default_nettype none
package cmtt_pkg;
  localparam int unsigned LeafBitsDef = 12;
  localparam int unsigned MaxLeaves   = 4;
  localparam int unsigned TruthW      = 16;
  localparam int unsigned SigW        = 32;
  localparam int unsigned LeavesW     = MaxLeaves * LeafBitsDef;

  typedef logic [TruthW-1:0] truth_t;

  // Input transaction: two cuts.
  typedef struct packed {
    logic [LeavesW-1:0] a_leaves;
    logic [2:0]         a_count;
    logic [TruthW-1:0]  a_truth;
    logic               a_invert;
    logic [LeavesW-1:0] b_leaves;
    logic [2:0]         b_count;
    logic [TruthW-1:0]  b_truth;
    logic               b_invert;
  } cut_pair_t;

  // Result transaction: merged cut.
  typedef struct packed {
    logic               merge_ok;
    logic [LeavesW-1:0] merged_leaves;
    logic [2:0]         merged_count;
    logic [TruthW-1:0]  merged_truth;
    logic [SigW-1:0]    merged_signature;
  } merged_cut_t;

  // Exchange variables lo and hi of a four-input truth table.
  function automatic truth_t swap_vars(truth_t t, logic [1:0] lo, logic [1:0] hi);
    truth_t r;
    r = t;
    unique case ({lo, hi})
      4'd1:  r = (t & 16'h9999) | ((t & 16'h4444) >> 1) | ((t & 16'h2222) << 1);
      4'd2:  r = (t & 16'hA5A5) | ((t & 16'h5050) >> 3) | ((t & 16'h0A0A) << 3);
      4'd3:  r = (t & 16'hAA55) | ((t & 16'h5500) >> 7) | ((t & 16'h00AA) << 7);
      4'd6:  r = (t & 16'hC3C3) | ((t & 16'h3030) >> 2) | ((t & 16'h0C0C) << 2);
      4'd7:  r = (t & 16'hCC33) | ((t & 16'h3300) >> 6) | ((t & 16'h00CC) << 6);
      4'd11: r = (t & 16'hF00F) | ((t & 16'h0F00) >> 4) | ((t & 16'h00F0) << 4);
      default: r = t;
    endcase
    return r;
  endfunction

  // True when the table does not depend on variable v.
  function automatic logic var_unused(truth_t t, logic [1:0] v);
    truth_t m;
    truth_t sh;
    m = 16'hAAAA;
    sh = 16'h0000;
    unique case (v)
      2'd0: begin m = 16'hAAAA; sh = (t & ~m) << 1; end
      2'd1: begin m = 16'hCCCC; sh = (t & ~m) << 2; end
      2'd2: begin m = 16'hF0F0; sh = (t & ~m) << 4; end
      default: begin m = 16'hFF00; sh = (t & ~m) << 8; end
    endcase
    return (t & m) == sh;
  endfunction
endpackage
`default_nettype wire

@@ rtl/cmtt_if.sv @@
// Valid/ready channel interface carrying a payload struct.
// Depends on nothing but the payload type handed in.
`default_nettype none
interface cmtt_if #(parameter type payload_t = logic) (input wire logic clk_i);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/cmtt_merge.sv @@
// Stage 1: sorted leaf merge with position maps. Depends on cmtt_pkg.
`default_nettype none
module cmtt_merge #(
  parameter int unsigned LeafBits = cmtt_pkg::LeafBitsDef
) (
  input  wire logic [4*LeafBits-1:0] a_leaves_i,
  input  wire logic [2:0]            a_count_i,
  input  wire logic [4*LeafBits-1:0] b_leaves_i,
  input  wire logic [2:0]            b_count_i,
  output logic                       ok_o,
  output logic [4*LeafBits-1:0]      leaves_o,
  output logic [2:0]                 count_o,
  output logic [7:0]                 pa_o,
  output logic [7:0]                 pb_o,
  output logic [2:0]                 na_o,
  output logic [2:0]                 nb_o
);
  logic [2:0] na, nb, i, j, n;
  logic [LeafBits-1:0] la, lb;
  // Walk the two lists, four emits at most.
  always_comb begin
    na = (a_count_i > 3'd4) ? 3'd4 : a_count_i;
    nb = (b_count_i > 3'd4) ? 3'd4 : b_count_i;
    i = '0; j = '0; n = '0;
    la = '0; lb = '0;
    leaves_o = '0; pa_o = '0; pb_o = '0;
    for (int s = 0; s < 4; s++) begin
      la = a_leaves_i[i[1:0]*LeafBits +: LeafBits];
      lb = b_leaves_i[j[1:0]*LeafBits +: LeafBits];
      if (i < na || j < nb) begin
        if (i < na && j < nb && la == lb) begin
          leaves_o[s*LeafBits +: LeafBits] = la;
          pa_o[i[1:0]*2 +: 2] = 2'(s); pb_o[j[1:0]*2 +: 2] = 2'(s);
          i = i + 3'd1; j = j + 3'd1;
        end else if (i < na && (j >= nb || la < lb)) begin
          leaves_o[s*LeafBits +: LeafBits] = la;
          pa_o[i[1:0]*2 +: 2] = 2'(s);
          i = i + 3'd1;
        end else begin
          leaves_o[s*LeafBits +: LeafBits] = lb;
          pb_o[j[1:0]*2 +: 2] = 2'(s);
          j = j + 3'd1;
        end
        n = n + 3'd1;
      end
    end
    ok_o = !(i < na || j < nb);
    count_o = n;
    na_o = na;
    nb_o = nb;
  end
endmodule
`default_nettype wire

@@ rtl/cmtt_remap.sv @@
// Stage 2: move both tables onto merged positions, invert and AND.
// Depends on cmtt_pkg.
`default_nettype none
module cmtt_remap (
  input  wire logic [15:0] a_truth_i,
  input  wire logic [15:0] b_truth_i,
  input  wire logic        a_invert_i,
  input  wire logic        b_invert_i,
  input  wire logic [7:0]  pa_i,
  input  wire logic [7:0]  pb_i,
  input  wire logic [2:0]  na_i,
  input  wire logic [2:0]  nb_i,
  output logic [15:0]      truth_o
);
  logic [15:0] ta, tb;
  // Swap from the highest cut position down.
  always_comb begin
    ta = a_truth_i;
    tb = b_truth_i;
    for (int k = 3; k >= 0; k--) begin
      if (3'(k) < na_i && pa_i[k*2 +: 2] != 2'(k))
        ta = cmtt_pkg::swap_vars(ta, 2'(k), pa_i[k*2 +: 2]);
      if (3'(k) < nb_i && pb_i[k*2 +: 2] != 2'(k))
        tb = cmtt_pkg::swap_vars(tb, 2'(k), pb_i[k*2 +: 2]);
    end
    if (a_invert_i) ta = ~ta;
    if (b_invert_i) tb = ~tb;
    truth_o = ta & tb;
  end
endmodule
`default_nettype wire

@@ rtl/cmtt_compact.sv @@
// Stage 3: drop unused variables, pack leaves, build signature.
// Depends on cmtt_pkg.
`default_nettype none
module cmtt_compact #(
  parameter int unsigned LeafBits = cmtt_pkg::LeafBitsDef
) (
  input  wire logic [4*LeafBits-1:0] leaves_i,
  input  wire logic [2:0]            count_i,
  input  wire logic [15:0]           truth_i,
  output logic [4*LeafBits-1:0]      leaves_o,
  output logic [2:0]                 count_o,
  output logic [15:0]                truth_o,
  output logic [31:0]                sig_o
);
  logic [2:0] s;
  logic [LeafBits-1:0] lf [4];
  // Shift used variables down in order.
  always_comb begin
    truth_o = truth_i;
    s = '0;
    for (int k = 0; k < 4; k++) lf[k] = leaves_i[k*LeafBits +: LeafBits];
    for (int k = 0; k < 4; k++) begin
      if (3'(k) < count_i && !cmtt_pkg::var_unused(truth_o, 2'(k))) begin
        if (3'(k) != s) begin
          lf[s[1:0]] = lf[k];
          truth_o = cmtt_pkg::swap_vars(truth_o, s[1:0], 2'(k));
        end
        s = s + 3'd1;
      end
    end
    leaves_o = '0;
    sig_o = '0;
    for (int k = 0; k < 4; k++) begin
      if (3'(k) < s) begin
        leaves_o[k*LeafBits +: LeafBits] = lf[k];
        sig_o[lf[k][4:0]] = 1'b1;
      end
    end
    count_o = s;
  end
endmodule
`default_nettype wire

@@ rtl/cut_merge_truth_table.sv @@
// Cut merge truth table: merges two four-leaf cuts of an AND node's fanins.
// Channels: in_if (sink) carries both cuts; out_if (source) carries the ok flag,
// merged leaves, count, truth table and 32-bit leaf signature.
// Pipeline: three register stages (merge, remap and AND, compaction); one
// transaction enters per cycle unless the receiver stalls. The first stage loads
// at the accepting edge; the result then passes the stage 2 and output registers
// to out_if.valid. Throughput is one item per cycle, set by the stage registers.
// Each stage holds a valid bit; a stage advances when it is empty or the next
// one moves, so a stalled receiver fills the pipe and then drops in_if.ready
// without losing or repeating any transaction.
// Reset clears all valid bits; payload registers are not reset.
// A failed merge returns ok 0 with every other field zero.
// The block has no configuration and no state between transactions.
// Leaf ids are LeafBits wide, four per cut.
`default_nettype none
module cut_merge_truth_table #(
  parameter int unsigned LeafBits = cmtt_pkg::LeafBitsDef
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  cmtt_if.sink     in_if,
  cmtt_if.source   out_if
);
  localparam int unsigned LW = 4 * LeafBits;
  localparam int unsigned LeavesW = cmtt_pkg::LeavesW;

  logic v1_q, v2_q, v3_q;
  logic adv1, adv2, adv3;

  // Stage 1 registers.
  logic          ok1_q;
  logic [LW-1:0] lv1_q;
  logic [2:0]    n1_q, na1_q, nb1_q;
  logic [7:0]    pa1_q, pb1_q;
  logic [15:0]   ta1_q, tb1_q;
  logic          ia1_q, ib1_q;
  // Stage 2 registers.
  logic          ok2_q;
  logic [LW-1:0] lv2_q;
  logic [2:0]    n2_q;
  logic [15:0]   t2_q;

  logic          ok1_d;
  logic [LW-1:0] lv1_d;
  logic [2:0]    n1_d, na1_d, nb1_d;
  logic [7:0]    pa1_d, pb1_d;
  logic [15:0]   t2_d;
  logic [LW-1:0] lv3_d;
  logic [2:0]    n3_d;
  logic [15:0]   t3_d;
  logic [31:0]   sig3_d;

  // Output register.
  logic          ok3_q;
  logic [LW-1:0] lv3_q;
  logic [2:0]    n3_q;
  logic [15:0]   t3_q;
  logic [31:0]   sig3_q;

  cmtt_pkg::merged_cut_t out_d;

  // Advance when the next stage is free or moving.
  assign adv3 = !v3_q || out_if.ready;
  assign adv2 = !v2_q || adv3;
  assign adv1 = !v1_q || adv2;
  assign in_if.ready = adv1;

  cmtt_merge #(.LeafBits(LeafBits)) u_merge (
    .a_leaves_i(in_if.data.a_leaves[LW-1:0]), .a_count_i(in_if.data.a_count),
    .b_leaves_i(in_if.data.b_leaves[LW-1:0]), .b_count_i(in_if.data.b_count),
    .ok_o(ok1_d), .leaves_o(lv1_d), .count_o(n1_d),
    .pa_o(pa1_d), .pb_o(pb1_d), .na_o(na1_d), .nb_o(nb1_d)
  );

  cmtt_remap u_remap (
    .a_truth_i(ta1_q), .b_truth_i(tb1_q), .a_invert_i(ia1_q), .b_invert_i(ib1_q),
    .pa_i(pa1_q), .pb_i(pb1_q), .na_i(na1_q), .nb_i(nb1_q), .truth_o(t2_d)
  );

  cmtt_compact #(.LeafBits(LeafBits)) u_compact (
    .leaves_i(lv2_q), .count_i(n2_q), .truth_i(t2_q),
    .leaves_o(lv3_d), .count_o(n3_d), .truth_o(t3_d), .sig_o(sig3_d)
  );

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= in_if.valid;
      if (adv2) v2_q <= v1_q;
      if (adv3) v3_q <= v2_q;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (adv1) begin
      ok1_q <= ok1_d; lv1_q <= lv1_d; n1_q <= n1_d;
      na1_q <= na1_d; nb1_q <= nb1_d; pa1_q <= pa1_d; pb1_q <= pb1_d;
      ta1_q <= in_if.data.a_truth; tb1_q <= in_if.data.b_truth;
      ia1_q <= in_if.data.a_invert; ib1_q <= in_if.data.b_invert;
    end
    if (adv2) begin
      ok2_q <= ok1_q; lv2_q <= lv1_q; n2_q <= n1_q; t2_q <= t2_d;
    end
    if (adv3) begin
      ok3_q  <= ok2_q;
      lv3_q  <= ok2_q ? lv3_d : '0;
      n3_q   <= ok2_q ? n3_d : 3'd0;
      t3_q   <= ok2_q ? t3_d : 16'd0;
      sig3_q <= ok2_q ? sig3_d : 32'd0;
    end
  end

  // Pack the output transaction.
  always_comb begin
    out_d.merge_ok = ok3_q;
    out_d.merged_leaves = LeavesW'(lv3_q);
    out_d.merged_count = n3_q;
    out_d.merged_truth = t3_q;
    out_d.merged_signature = sig3_q;
  end

  assign out_if.valid = v3_q;
  assign out_if.data = out_d;
endmodule
`default_nettype wire

@@ verif/testbench.sv @@
// Testbench for cut_merge_truth_table: drives cut pairs over the valid/ready
// input channel and checks every merged cut against an internal predictor.
// Depends on cmtt_pkg, the cmtt_if interface and the block itself.
`timescale 1ns / 100ps

module testbench;
  localparam int unsigned LB = cmtt_pkg::LeafBitsDef;
  localparam int unsigned LW = cmtt_pkg::MaxLeaves * LB;
  localparam int unsigned PAIR_W = $bits(cmtt_pkg::cut_pair_t);
  localparam int unsigned NUM_RANDOM = 1000;
  localparam int unsigned HOLD_CYCLES = 200;

  typedef enum int {
    PH_FREE, PH_SRC_IDLE, PH_SNK_STALL, PH_BOTH
  } phase_e;

  logic clk_i;
  logic rst_ni;

  cmtt_if #(.payload_t(cmtt_pkg::cut_pair_t))   in_if (clk_i);
  cmtt_if #(.payload_t(cmtt_pkg::merged_cut_t)) out_if (clk_i);

  cut_merge_truth_table DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if),
    .out_if (out_if)
  );

  // Exchange two variables of a four-input table by permuting minterm indexes.
  function automatic cmtt_pkg::truth_t exchange_vars(cmtt_pkg::truth_t t, int lo, int hi);
    cmtt_pkg::truth_t r;
    int     m;
    int     p;
    for (m = 0; m < 16; m++) begin
      p = m;
      p[lo] = m[hi];
      p[hi] = m[lo];
      r[p] = t[m];
    end
    return r;
  endfunction

  // True when both cofactors of variable v agree.
  function automatic bit ignores_var(cmtt_pkg::truth_t t, int v);
    int m;
    for (m = 0; m < 16; m++)
      if (m[v] && t[m] != t[m ^ (1 << v)]) return 0;
    return 1;
  endfunction

  // Compute the merged cut for one cut pair.
  function automatic cmtt_pkg::merged_cut_t merge_cuts(cmtt_pkg::cut_pair_t x);
    cmtt_pkg::merged_cut_t r;
    int          la[4], lb[4], pa[4], pb[4], ml[4];
    int          na, nb, i, j, n, k, s;
    cmtt_pkg::truth_t ta, tb, t;
    r = '0;
    na = (x.a_count > 3'd4) ? 4 : int'(x.a_count);
    nb = (x.b_count > 3'd4) ? 4 : int'(x.b_count);
    for (k = 0; k < 4; k++) begin
      la[k] = int'(x.a_leaves[k*LB +: LB]);
      lb[k] = int'(x.b_leaves[k*LB +: LB]);
      pa[k] = 0; pb[k] = 0; ml[k] = 0;
    end
    i = 0; j = 0; n = 0;
    // Merge in one ascending pass, taking equal heads once.
    while (n < cmtt_pkg::MaxLeaves && (i < na || j < nb)) begin
      if (i < na && j < nb && la[i] == lb[j]) begin
        ml[n] = la[i]; pa[i] = n; pb[j] = n; i++; j++;
      end else if (i < na && (j >= nb || la[i] < lb[j])) begin
        ml[n] = la[i]; pa[i] = n; i++;
      end else begin
        ml[n] = lb[j]; pb[j] = n; j++;
      end
      n++;
    end
    if (i < na || j < nb) return r;
    ta = x.a_truth;
    tb = x.b_truth;
    for (k = na - 1; k >= 0; k--) if (pa[k] != k) ta = exchange_vars(ta, k, pa[k]);
    for (k = nb - 1; k >= 0; k--) if (pb[k] != k) tb = exchange_vars(tb, k, pb[k]);
    if (x.a_invert) ta = ~ta;
    if (x.b_invert) tb = ~tb;
    t = ta & tb;
    // Compact away leaves outside the support.
    s = 0;
    for (k = 0; k < n; k++) begin
      if (!ignores_var(t, k)) begin
        if (k != s) begin
          ml[s] = ml[k];
          t = exchange_vars(t, s, k);
        end
        s++;
      end
    end
    r.merge_ok = 1'b1;
    for (k = 0; k < s; k++) begin
      r.merged_leaves[k*LB +: LB] = LB'(ml[k]);
      r.merged_signature[ml[k] % 32] = 1'b1;
    end
    r.merged_count = 3'(s);
    r.merged_truth = t;
    return r;
  endfunction

  class merge_scoreboard;
    cmtt_pkg::merged_cut_t pending[$];
    int          errors = 0;
    int          checked = 0;
    int          ok_seen = 0;

    function void note_input(cmtt_pkg::cut_pair_t x);
      pending.insert(pending.size(), merge_cuts(x));
    endfunction

    function void check_result(cmtt_pkg::merged_cut_t got);
      cmtt_pkg::merged_cut_t exp;
      if (pending.size() == 0) begin
        $error("merged cut with no pending transaction: %h", got);
        errors++;
        return;
      end
      exp = pending.pop_front();
      checked++;
      if (exp.merge_ok) ok_seen++;
      if (got.merge_ok !== exp.merge_ok) begin
        $error("merge_ok expected %0h actual %0h", exp.merge_ok, got.merge_ok); errors++;
      end
      if (got.merged_leaves !== exp.merged_leaves) begin
        $error("merged_leaves expected %h actual %h", exp.merged_leaves,
               got.merged_leaves); errors++;
      end
      if (got.merged_count !== exp.merged_count) begin
        $error("merged_count expected %0d actual %0d", exp.merged_count,
               got.merged_count); errors++;
      end
      if (got.merged_truth !== exp.merged_truth) begin
        $error("merged_truth expected %h actual %h", exp.merged_truth,
               got.merged_truth); errors++;
      end
      if (got.merged_signature !== exp.merged_signature) begin
        $error("merged_signature expected %h actual %h", exp.merged_signature,
               got.merged_signature); errors++;
      end
    endfunction
  endclass

  merge_scoreboard sb;
  phase_e          phase;
  int              sent;
  bit              hold_req;
  cmtt_pkg::cut_pair_t directed[$];

  // Queue one directed case.
  function automatic void add_case(cmtt_pkg::cut_pair_t x);
    directed.insert(directed.size(), x);
  endfunction

  // Generate the clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop for a hung run.
  initial begin
    #5ms;
    $display("FAIL");
    $finish;
  end

  // Build an ascending cut; ids below count come from a shared window when tight.
  function automatic logic [LW-1:0] make_leaves(int cnt, bit tight, int base);
    logic [LW-1:0] v;
    int            k, id;
    v = LW'({$urandom, $urandom});
    id = tight ? base + int'($urandom_range(0, 2)) : int'($urandom_range(0, 600));
    for (k = 0; k < cnt; k++) begin
      v[k*LB +: LB] = LB'(id);
      id += tight ? int'($urandom_range(1, 2)) : int'($urandom_range(1, 1100));
    end
    return v;
  endfunction

  function automatic cmtt_pkg::cut_pair_t make_pair();
    cmtt_pkg::cut_pair_t x;
    bit        tight;
    int        base;
    x = PAIR_W'({$urandom, $urandom, $urandom, $urandom, $urandom});
    if ($urandom_range(0, 9) < 8) begin
      tight = $urandom_range(0, 3) != 0;
      base = int'($urandom_range(0, (1 << LB) - 12));
      x.a_count = 3'($urandom_range(0, 4));
      x.b_count = 3'($urandom_range(0, 4));
      x.a_leaves = make_leaves(int'(x.a_count), tight, base);
      x.b_leaves = make_leaves(int'(x.b_count), tight, base);
    end
    return x;
  endfunction

  function automatic cmtt_pkg::cut_pair_t pair_of(
      logic [LW-1:0] al, int ac, cmtt_pkg::truth_t at, bit ai,
      logic [LW-1:0] bl, int bc, cmtt_pkg::truth_t bt, bit bi);
    cmtt_pkg::cut_pair_t x;
    x.a_leaves = al; x.a_count = 3'(ac); x.a_truth = at; x.a_invert = ai;
    x.b_leaves = bl; x.b_count = 3'(bc); x.b_truth = bt; x.b_invert = bi;
    return x;
  endfunction

  // Pick an idle gap for the sender in the current phase.
  function automatic int src_gap();
    int pct;
    pct = (phase == PH_SRC_IDLE) ? 53 : (phase == PH_BOTH) ? 24 : 0;
    return ($urandom_range(0, 99) < pct) ? int'($urandom_range(1, 3)) : 0;
  endfunction

  // Offer one transaction and hold it until accepted.
  task automatic send_pair(cmtt_pkg::cut_pair_t x);
    int gap;
    gap = src_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= x;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_input(x);
    sent++;
  endtask

  // Receiver: check results, stall at random, hold off on request.
  initial begin
    int pct;
    int hold_left;
    hold_left = 0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_if.valid && out_if.ready) sb.check_result(out_if.data);
      if (hold_req && hold_left == 0) begin
        hold_left = HOLD_CYCLES;
        hold_req = 0;
      end
      pct = (phase == PH_SNK_STALL) ? 53 : (phase == PH_BOTH) ? 24 : 0;
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(0, 99) >= pct);
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    int k, wait_cycles;
    sb = new();
    phase = PH_FREE;
    sent = 0;
    hold_req = 0;
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.data = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed cases: extremes, inversion, overflow, empty, unsorted and repeats.
    add_case(pair_of('0, 0, 16'h0000, 0, '0, 0, 16'h0000, 0));
    add_case(pair_of('1, 7, 16'hFFFF, 1, '1, 7, 16'hFFFF, 1));
    add_case(pair_of('0, 0, 16'hFFFF, 0, '0, 0, 16'hFFFF, 1));
    add_case(pair_of({12'd4, 12'd3, 12'd2, 12'd1}, 4, 16'h8000, 0,
                     {12'd4, 12'd3, 12'd2, 12'd1}, 4, 16'hFFFE, 0));
    add_case(pair_of({12'd4, 12'd3, 12'd2, 12'd1}, 4, 16'hAAAA, 0,
                     {12'd8, 12'd7, 12'd6, 12'd5}, 4, 16'hCCCC, 0));
    add_case(pair_of({36'd0, 12'd5}, 1, 16'hAAAA, 0,
                     {36'd0, 12'd9}, 1, 16'hAAAA, 1));
    add_case(pair_of({24'd0, 12'd30, 12'd2}, 2, 16'h8888, 1,
                     {24'd0, 12'd40, 12'd2}, 2, 16'h6666, 0));
    add_case(pair_of({12'hFFF, 12'hFFE, 12'hFFD, 12'hFFC}, 4, 16'h1234, 0,
                     {12'hFFF, 12'hFFE, 12'hFFD, 12'hFFC}, 6, 16'hFEDC, 1));
    add_case(pair_of({12'd1, 12'd9, 12'd3, 12'd7}, 4, 16'h5A3C, 0,
                     {36'd0, 12'd3}, 1, 16'hAAAA, 0));
    add_case(pair_of({12'd3, 12'd3, 12'd3, 12'd3}, 4, 16'hC0C0, 0,
                     {12'd3, 12'd3, 12'd3, 12'd3}, 4, 16'h0F0F, 1));
    add_case(pair_of({24'd0, 12'd20, 12'd10}, 2, 16'hCCCC, 0,
                     '0, 0, 16'hAAAA, 0));
    add_case(pair_of({12'd0, 12'd63, 12'd32, 12'd31}, 3, 16'hF0F0, 0,
                     {12'd0, 12'd96, 12'd64, 12'd33}, 3, 16'hAAAA, 0));
    add_case(pair_of({12'd0, 12'd3, 12'd2, 12'd1}, 3, 16'hFF00, 0,
                     {12'd0, 12'd0, 12'd5, 12'd4}, 2, 16'h0000, 1));
    add_case(pair_of({12'd0, 12'd3, 12'd2, 12'd1}, 3, 16'h9669, 0,
                     {12'd0, 12'd0, 12'd5, 12'd4}, 2, 16'h6996, 1));
    for (k = 0; k < directed.size(); k++) send_pair(directed[k]);

    // Random part, four idling phases; one long receiver hold in the first.
    for (k = 0; k < NUM_RANDOM; k++) begin
      phase = phase_e'(k / (NUM_RANDOM / 4));
      if (k == 100) hold_req = 1;
      send_pair(make_pair());
    end
    // Drop valid right after the last acceptance.
    in_if.valid <= 1'b0;

    // Drain.
    wait_cycles = 0;
    while (sb.pending.size() != 0 && wait_cycles < 20000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (10) @(posedge clk_i);
    if (sb.pending.size() != 0) begin
      $error("%0d merged cuts never arrived", sb.pending.size());
      sb.errors++;
    end
    $display("Sent %0d cut pairs, checked %0d merged cuts (%0d merged ok),",
             sent, sb.checked, sb.ok_seen);
    $display("across free-running, sender-idle, receiver-stall and mixed phases.");
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

@@ cut_merge_truth_table.f @@
rtl/cmtt_pkg.sv
rtl/cmtt_if.sv
rtl/cmtt_merge.sv
rtl/cmtt_remap.sv
rtl/cmtt_compact.sv
rtl/cut_merge_truth_table.sv
verif/testbench.sv
